[hdl/mwl_pkg.sv]
// Package for the shortest-window block: sizes, item types, engine states.
// No dependencies; every other file in hdl imports it.
`default_nettype none

package mwl_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_W      = 16;
    localparam int THR_W        = 32;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_W        = 11;
    localparam int SUM_W        = VALUE_W + OCC_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic             found;
        logic             overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_CHECK,
        ST_DROP,
        ST_EMIT
    } t_eng_state;

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(WINDOW_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/mwl_in_queue.sv]
// Front side: small input queue that takes words from the push port and
// hands them to the engine in order. Depends on mwl_pkg.
`default_nettype none

module mwl_in_queue
    import mwl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_in_item      o_item
);

    t_in_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_head;
    logic [QPTR_W-1:0]  r_tail;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

endmodule

`default_nettype wire

[hdl/mwl_engine.sv]
// Back side: window store, running sum, shrink loop and result register.
// Depends on mwl_pkg; fed by mwl_in_queue.
`default_nettype none

module mwl_engine
    import mwl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [THR_W-1:0] i_threshold,
    input  wire logic             i_q_valid,
    input  wire t_in_item         i_q_item,
    output logic                  o_q_pop,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output t_out_item             o_result
);

    logic [VALUE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [VALUE_W-1:0] r_rd;

    t_eng_state         r_state,   n_state;
    logic [SUM_W-1:0]   r_sum,     n_sum;
    logic [ADDR_W-1:0]  r_front,   n_front;
    logic [ADDR_W-1:0]  r_back,    n_back;
    logic [OCC_W-1:0]   r_occ,     n_occ;
    logic [LEN_W-1:0]   r_best,    n_best;
    logic               r_best_ok, n_best_ok;
    logic               r_ovf,     n_ovf;
    logic               r_last,    n_last;
    logic [VALUE_W-1:0] r_val,     n_val;
    logic               r_res_ok,  n_res_ok;
    t_out_item          r_res,     n_res;

    logic               w_we;
    logic [VALUE_W-1:0] w_wdata;
    logic               w_re;
    logic               w_hit;
    logic [SUM_W-1:0]   w_rd_ext;
    logic [SUM_W-1:0]   w_val_ext;

    assign o_empty  = !r_res_ok;
    assign o_result = r_res;

    assign w_rd_ext  = {{(SUM_W - VALUE_W){1'b0}}, r_rd};
    assign w_val_ext = {{(SUM_W - VALUE_W){1'b0}}, r_val};
    assign w_hit     = (r_occ != '0) &&
                       ({{(THR_W - SUM_W){1'b0}}, r_sum} >= i_threshold);

    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_front   = r_front;
        n_back    = r_back;
        n_occ     = r_occ;
        n_best    = r_best;
        n_best_ok = r_best_ok;
        n_ovf     = r_ovf;
        n_last    = r_last;
        n_val     = r_val;
        n_res_ok  = r_res_ok;
        n_res     = r_res;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        w_wdata   = r_val;
        w_re      = 1'b0;

        if (i_pop && r_res_ok) begin
            n_res_ok = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_val   = i_q_item.value;
                    n_last  = i_q_item.last;
                    if (r_occ == OCC_W'(WINDOW_DEPTH)) begin
                        // store full: fetch the front word before it is overwritten
                        n_ovf   = 1'b1;
                        w_re    = 1'b1;
                        n_state = ST_EVICT;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = i_q_item.value;
                        n_back  = addr_inc(r_back);
                        n_occ   = r_occ + 1'b1;
                        n_sum   = r_sum + {{(SUM_W - VALUE_W){1'b0}}, i_q_item.value};
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_EVICT: begin
                // drop front and push in one step; occupancy stays at depth
                w_we    = 1'b1;
                n_sum   = r_sum - w_rd_ext + w_val_ext;
                n_front = addr_inc(r_front);
                n_back  = addr_inc(r_back);
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit) begin
                    if (!r_best_ok || (LEN_W'(r_occ) < r_best)) begin
                        n_best    = LEN_W'(r_occ);
                        n_best_ok = 1'b1;
                    end
                    w_re    = 1'b1;
                    n_state = ST_DROP;
                end else if (r_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DROP: begin
                n_sum   = r_sum - w_rd_ext;
                n_front = addr_inc(r_front);
                n_occ   = r_occ - 1'b1;
                n_state = ST_CHECK;
            end
            ST_EMIT: begin
                // hold until the result register is free
                if (!r_res_ok || i_pop) begin
                    n_res_ok           = 1'b1;
                    n_res.min_length   = r_best_ok ? r_best : '0;
                    n_res.found        = r_best_ok;
                    n_res.overflow     = r_ovf;
                    n_sum              = '0;
                    n_front            = '0;
                    n_back             = '0;
                    n_occ              = '0;
                    n_best             = '0;
                    n_best_ok          = 1'b0;
                    n_ovf              = 1'b0;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sum     <= '0;
            r_front   <= '0;
            r_back    <= '0;
            r_occ     <= '0;
            r_best    <= '0;
            r_best_ok <= 1'b0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
            r_res_ok  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_front   <= n_front;
            r_back    <= n_back;
            r_occ     <= n_occ;
            r_best    <= n_best;
            r_best_ok <= n_best_ok;
            r_ovf     <= n_ovf;
            r_last    <= n_last;
            r_res_ok  <= n_res_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_back] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd <= r_mem[r_front];
        end
    end

endmodule

`default_nettype wire

[hdl/min_window_length_sum_at_least_top.sv]
// Channel    Direction  Handshake                 Payload
// input      in         i_push / o_full           i_item   (t_in_item)
// result     out        i_pop / o_empty           o_result (t_out_item)
// config     in         i_cfg_we                  i_cfg_wdata (threshold)
//
// An item takes a push step and a compare step, plus a drop step and another
// compare for every front word dropped: the window store's registered read
// port sits in each drop. A push into a full store adds an evict step; a last
// item adds a step to load the result register. Synchronous reset clears all
// control state and sets the threshold to 1; the window store is not cleared.
// The input queue keeps accepting words while a result waits to be popped.
//
// Top level: threshold register, input queue, engine. Depends on mwl_pkg,
// mwl_in_queue and mwl_engine.
`default_nettype none

module min_window_length_sum_at_least_top
    import mwl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_in_item         i_item,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output t_out_item             o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    logic [THR_W-1:0] r_threshold;
    logic             w_q_valid;
    logic             w_q_pop;
    t_in_item         w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_W'(1);
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    mwl_in_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    mwl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.found) |->
        (o_result.min_length != '0) && (o_result.min_length <= LEN_W'(WINDOW_DEPTH)))
        else $error("found result with out-of-range length");

    a_none_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_result.found) |-> (o_result.min_length == '0))
        else $error("not-found result with nonzero length");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire
